// ----- design/itrt_pkg.sv -----
// Shared types, constants and helper functions for the integer to Roman text block.
// Used by the front converter, the queue, the character sequencer and the top level.
// No dependencies.
package itrt_pkg;

    // Width of the binary input and the packed BCD form.
    localparam int BIN_W = 12;
    localparam int BCD_W = 16;
    localparam int CHAR_W = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BIN_W-1:0] NUMBER_MAX = 12'd3999;

    // ASCII codes of the characters the block emits.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_EQ = 7'h3D;
    localparam logic [CHAR_W-1:0] ASCII_M = 7'h4D;
    localparam logic [CHAR_W-1:0] ASCII_D = 7'h44;
    localparam logic [CHAR_W-1:0] ASCII_C = 7'h43;
    localparam logic [CHAR_W-1:0] ASCII_L = 7'h4C;
    localparam logic [CHAR_W-1:0] ASCII_X = 7'h58;
    localparam logic [CHAR_W-1:0] ASCII_V = 7'h56;
    localparam logic [CHAR_W-1:0] ASCII_I = 7'h49;

    // Digit positions: thousands first, units last.
    localparam logic [1:0] POS_THOUSANDS = 2'd0;
    localparam logic [1:0] POS_HUNDREDS = 2'd1;
    localparam logic [1:0] POS_TENS = 2'd2;
    localparam logic [1:0] POS_UNITS = 2'd3;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [3:0] digit_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [1:0] pos_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DEC,
        B_EQ,
        B_ROM
    } back_state_t;

    // Handshake from the front converter towards the queue.
    typedef struct packed {
        logic valid;
        bcd_t bcd;
    } push_t;

    // Handshake from the queue towards the sequencer.
    typedef struct packed {
        logic empty;
        logic full;
        bcd_t bcd;
    } queue_status_t;

    // Pick one decimal digit out of the packed BCD word.
    function automatic digit_t get_digit(input bcd_t bcd, input pos_t pos);
        digit_t d;
        unique case (pos)
            POS_THOUSANDS: d = bcd[15:12];
            POS_HUNDREDS:  d = bcd[11:8];
            POS_TENS:      d = bcd[7:4];
            default:       d = bcd[3:0];
        endcase
        return d;
    endfunction

    // True when every digit after the given position is zero.
    function automatic logic lower_zero(input bcd_t bcd, input pos_t pos);
        logic z;
        unique case (pos)
            POS_THOUSANDS: z = (bcd[11:0] == 12'd0);
            POS_HUNDREDS:  z = (bcd[7:0] == 8'd0);
            POS_TENS:      z = (bcd[3:0] == 4'd0);
            default:       z = 1'b1;
        endcase
        return z;
    endfunction

    // Roman letter worth one unit of the digit position.
    function automatic char_t letter_one(input pos_t pos);
        char_t c;
        unique case (pos)
            POS_THOUSANDS: c = ASCII_M;
            POS_HUNDREDS:  c = ASCII_C;
            POS_TENS:      c = ASCII_X;
            default:       c = ASCII_I;
        endcase
        return c;
    endfunction

    // Roman letter worth five units; thousands never need one.
    function automatic char_t letter_five(input pos_t pos);
        char_t c;
        unique case (pos)
            POS_HUNDREDS: c = ASCII_D;
            POS_TENS:     c = ASCII_L;
            POS_UNITS:    c = ASCII_V;
            default:      c = ASCII_M;
        endcase
        return c;
    endfunction

    // Roman letter worth ten units of the position.
    function automatic char_t letter_ten(input pos_t pos);
        char_t c;
        unique case (pos)
            POS_HUNDREDS: c = ASCII_M;
            POS_TENS:     c = ASCII_C;
            POS_UNITS:    c = ASCII_X;
            default:      c = ASCII_M;
        endcase
        return c;
    endfunction

endpackage

// ----- design/itrt_front.sv -----
// Front part: accepts a number, clamps it to 3999 and converts it to BCD by
// shift and add-three, one bit a cycle. Depends on itrt_pkg.
module itrt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 number_valid,
    output logic                 number_stall,
    input  logic [11:0]          number,
    input  logic                 queue_full,
    output itrt_pkg::push_t      push
);
    import itrt_pkg::*;

    front_state_t      state_reg, state_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    bcd_t              bcd_reg, bcd_next;
    logic [3:0]        cnt_reg, cnt_next;
    bcd_t              bcd_adj;

    // Add three to every BCD digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    assign number_stall = (state_reg != F_IDLE);
    assign push.valid = (state_reg == F_PUSH);
    assign push.bcd = bcd_reg;

    // Next state and data path of the converter.
    always_comb
    begin
        state_next = state_reg;
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (number_valid)
                begin
                    bin_next = (number > NUMBER_MAX) ? NUMBER_MAX : number;
                    bcd_next = '0;
                    cnt_next = '0;
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                // The top BCD bit is never set for values up to 3999.
                {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(BIN_W - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    // Conversion data.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

// ----- design/itrt_queue.sv -----
// Two-entry queue of converted BCD values between the front and back parts.
// Depends on itrt_pkg.
module itrt_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  itrt_pkg::push_t            push,
    input  logic                       pop,
    output itrt_pkg::queue_status_t    status
);
    import itrt_pkg::*;

    bcd_t        entry_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign status.empty = (count_reg == 2'd0);
    assign status.full = (count_reg == 2'(QUEUE_DEPTH));
    assign status.bcd = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !status.full;
    assign do_pop = pop && !status.empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.bcd;
    end

endmodule

// ----- design/itrt_back.sv -----
// Back part: walks the BCD digits of one item and emits the decimal text, '='
// and the Roman numeral (none for zero), one character a cycle unless stalled,
// into an output register. Depends on itrt_pkg.
module itrt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  itrt_pkg::queue_status_t     status,
    output logic                        pop,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [6:0]                  character,
    output logic                        last
);
    import itrt_pkg::*;

    back_state_t  state_reg, state_next;
    bcd_t         bcd_reg, bcd_next;
    pos_t         pos_reg, pos_next;
    digit_t       rem_reg, rem_next;
    logic         pend_reg, pend_next;
    char_t        pend_char_reg, pend_char_next;
    logic         out_valid_reg, out_valid_next;
    char_t        out_char_reg, out_char_next;
    logic         out_last_reg, out_last_next;

    logic         adv;
    logic         emit;
    char_t        emit_char;
    logic         lz;
    pos_t         first_pos;
    digit_t       rem_after;
    logic         pend_after;

    assign result_valid = out_valid_reg;
    assign character = out_char_reg;
    assign last = out_last_reg;

    // The sequencer moves on when the output register is free or being taken.
    assign adv = !out_valid_reg || !result_stall;
    assign lz = lower_zero(bcd_reg, pos_reg);

    // Position of the leading decimal digit; units when the value is zero.
    always_comb
    begin
        priority if (status.bcd[15:12] != 4'd0)
            first_pos = POS_THOUSANDS;
        else if (status.bcd[11:8] != 4'd0)
            first_pos = POS_HUNDREDS;
        else if (status.bcd[7:4] != 4'd0)
            first_pos = POS_TENS;
        else
            first_pos = POS_UNITS;
    end

    // Sequencer next state and character selection.
    always_comb
    begin
        state_next = state_reg;
        bcd_next = bcd_reg;
        pos_next = pos_reg;
        rem_next = rem_reg;
        pend_next = pend_reg;
        pend_char_next = pend_char_reg;
        pop = 1'b0;
        emit = 1'b0;
        emit_char = ASCII_EQ;
        rem_after = rem_reg;
        pend_after = 1'b0;
        out_valid_next = out_valid_reg;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!status.empty)
                begin
                    pop = 1'b1;
                    bcd_next = status.bcd;
                    pos_next = first_pos;
                    state_next = B_DEC;
                end
            end
            B_DEC:
            begin
                if (adv)
                begin
                    emit = 1'b1;
                    emit_char = ASCII_ZERO + char_t'(get_digit(bcd_reg, pos_reg));
                    out_last_next = 1'b0;
                    if (pos_reg == POS_UNITS)
                        state_next = B_EQ;
                    else
                        pos_next = pos_reg + 2'd1;
                end
            end
            B_EQ:
            begin
                if (adv)
                begin
                    emit = 1'b1;
                    emit_char = ASCII_EQ;
                    out_last_next = (bcd_reg == '0);
                    pend_next = 1'b0;
                    if (bcd_reg == '0)
                        state_next = B_IDLE;
                    else
                    begin
                        pos_next = POS_THOUSANDS;
                        rem_next = get_digit(bcd_reg, POS_THOUSANDS);
                        state_next = B_ROM;
                    end
                end
            end
            B_ROM:
            begin
                if (adv)
                begin
                    // Greedy choice within one digit position.
                    priority if (pend_reg)
                    begin
                        emit = 1'b1;
                        emit_char = pend_char_reg;
                    end
                    else if (rem_reg == 4'd0)
                    begin
                        emit = 1'b0;
                    end
                    else if (rem_reg == 4'd9)
                    begin
                        emit = 1'b1;
                        emit_char = letter_one(pos_reg);
                        pend_after = 1'b1;
                        pend_char_next = letter_ten(pos_reg);
                        rem_after = 4'd0;
                    end
                    else if (rem_reg >= 4'd5)
                    begin
                        emit = 1'b1;
                        emit_char = letter_five(pos_reg);
                        rem_after = rem_reg - 4'd5;
                    end
                    else if (rem_reg == 4'd4)
                    begin
                        emit = 1'b1;
                        emit_char = letter_one(pos_reg);
                        pend_after = 1'b1;
                        pend_char_next = letter_five(pos_reg);
                        rem_after = 4'd0;
                    end
                    else
                    begin
                        emit = 1'b1;
                        emit_char = letter_one(pos_reg);
                        rem_after = rem_reg - 4'd1;
                    end

                    pend_next = pend_after;
                    rem_next = rem_after;
                    out_last_next = !pend_after && (rem_after == 4'd0) && lz;

                    // Digit finished: go to the next position or end the run.
                    if (!pend_after && (rem_after == 4'd0))
                    begin
                        if (lz)
                            state_next = B_IDLE;
                        else
                        begin
                            pos_next = pos_reg + 2'd1;
                            rem_next = get_digit(bcd_reg, pos_reg + 2'd1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // Output register: loaded whenever the sequencer advances outside idle; in idle its valid flag is cleared.
        if (adv && state_reg != B_IDLE)
        begin
            out_valid_next = emit;
            out_char_next = emit_char;
        end
        else if (adv)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        pos_reg <= pos_next;
        rem_reg <= rem_next;
        pend_char_reg <= pend_char_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- design/integer_to_roman_text_core.sv -----
// Top level of the integer to Roman text block.
// Instantiates itrt_front, itrt_queue and itrt_back; depends on itrt_pkg.
//
// Usage:
//   Input channel: number (12 bits) with number_valid and number_stall. An item is
//   taken on a rising edge with number_valid high and number_stall low. Values
//   above 3999 are clamped to 3999.
//   Output channel: character (7-bit ASCII) and last, with result_valid and
//   result_stall. Each item produces its decimal text, '=', then the Roman
//   numeral (none for zero), one character per accepted result; last marks the final one.
//   Sequence: the front converts each item to BCD and pushes it into the queue;
//   the back pops it and presents each character through its output register.
//   Throughput: the back sequencer emits one character a cycle while
//   result_stall is low, pausing for each item to load it and at each zero
//   digit ahead of the last non-zero one; the front takes a new item once it
//   has pushed the last one, overlapping with the back through a two-entry queue.
//   Reset: rst_n clears the queue, the converter and the output register; no
//   result is valid after reset.
//   Stall: while result_stall is high the character is held and the sequencer
//   waits; the queue then fills, the front holds its converted value, and
//   number_stall stays high until there is room again.
module integer_to_roman_text_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        number_valid,
    output logic        number_stall,
    input  logic [11:0] number,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [6:0]  character,
    output logic        last
);
    import itrt_pkg::*;

    push_t          push;
    queue_status_t  status;
    logic           pop;

    itrt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_stall (number_stall),
        .number       (number),
        .queue_full   (status.full),
        .push         (push)
    );

    itrt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (status)
    );

    itrt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .status       (status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .character    (character),
        .last         (last)
    );

endmodule
